// ----- hdl/urxto_pkg.sv -----
`default_nettype none
package urxto_pkg;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_ENABLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS  = 2'd2;

    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned COUNT_W    = 16;
    localparam int unsigned DATA_W     = 8;

    // reset values of the registers
    localparam logic [COUNT_W-1:0] BIT_PERIOD_RST     = 16'd104;
    localparam logic               TIMEOUT_ENABLE_RST = 1'b0;
    localparam logic [COUNT_W-1:0] TIMEOUT_TICKS_RST  = 16'd8000;

    // result event codes
    localparam logic EV_BYTE    = 1'b0;
    localparam logic EV_TIMEOUT = 1'b1;

    typedef struct packed {
        logic [COUNT_W-1:0] bit_period;
        logic               timeout_enable;
        logic [COUNT_W-1:0] timeout_ticks;
    } t_cfg;

    typedef struct packed {
        logic              event_res;
        logic [DATA_W-1:0] data;
    } t_result;

endpackage
`default_nettype wire

// ----- hdl/urxto_cfg.sv -----
`default_nettype none
module urxto_cfg (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire  [urxto_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [urxto_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output urxto_pkg::t_cfg                      o_cfg
);

    urxto_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bit_period     <= urxto_pkg::BIT_PERIOD_RST;
            r_cfg.timeout_enable <= urxto_pkg::TIMEOUT_ENABLE_RST;
            r_cfg.timeout_ticks  <= urxto_pkg::TIMEOUT_TICKS_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                urxto_pkg::CFG_BIT_PERIOD:     r_cfg.bit_period     <= i_cfg_data;
                urxto_pkg::CFG_TIMEOUT_ENABLE: r_cfg.timeout_enable <= i_cfg_data[0];
                urxto_pkg::CFG_TIMEOUT_TICKS:  r_cfg.timeout_ticks  <= i_cfg_data;
                default: begin
                    // unused index, write dropped
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- hdl/urxto_core.sv -----
`default_nettype none
module urxto_core (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_step,
    input  wire                 i_rx_line,
    input  wire                 i_listen,
    input  urxto_pkg::t_cfg     i_cfg,
    output logic                o_res_valid,
    output urxto_pkg::t_result  o_res
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_WAIT = 2'd1;
    localparam logic [1:0] PH_RECV = 2'd2;

    localparam logic [urxto_pkg::COUNT_W-1:0] CNT_ONE = {{(urxto_pkg::COUNT_W-1){1'b0}}, 1'b1};
    localparam logic [urxto_pkg::COUNT_W-1:0] CNT_MAX = {urxto_pkg::COUNT_W{1'b1}};
    localparam logic [3:0] BIT_FIRST_DATA = 4'd1;
    localparam logic [3:0] BIT_LAST_DATA  = 4'd8;
    localparam logic [3:0] BIT_STOP       = 4'd9;

    function automatic logic [urxto_pkg::COUNT_W-1:0] reload(
        input logic [urxto_pkg::COUNT_W-1:0] v
    );
        return (v == '0) ? CNT_ONE : v;
    endfunction

    logic [1:0]                      r_phase,      n_phase;
    logic [urxto_pkg::COUNT_W-1:0]   r_tick_count, n_tick_count;
    logic [3:0]                      r_bit_index,  n_bit_index;
    logic [urxto_pkg::DATA_W-1:0]    r_shift_data, n_shift_data;
    logic [urxto_pkg::COUNT_W-1:0]   r_wait_count, n_wait_count;

    logic [1:0]                      eff_phase;
    logic                            go_wait;
    logic [urxto_pkg::COUNT_W-1:0]   wait_base;
    logic [urxto_pkg::COUNT_W-1:0]   wait_inc;

    always_comb begin
        // the unused phase code behaves as idle
        eff_phase = ((r_phase == PH_WAIT) || (r_phase == PH_RECV)) ? r_phase : PH_IDLE;
        // the arming tick is itself a waiting tick
        go_wait   = (eff_phase == PH_WAIT) || ((eff_phase == PH_IDLE) && i_listen);
        wait_base = (eff_phase == PH_WAIT) ? r_wait_count : '0;
        wait_inc  = (wait_base == CNT_MAX) ? wait_base : wait_base + CNT_ONE;

        n_phase      = r_phase;
        n_tick_count = r_tick_count;
        n_bit_index  = r_bit_index;
        n_shift_data = r_shift_data;
        n_wait_count = r_wait_count;
        o_res_valid  = 1'b0;
        o_res        = '0;

        if (i_step) begin
            if (go_wait) begin
                n_phase      = PH_WAIT;
                n_wait_count = wait_base;
                if (!i_rx_line) begin
                    // start bit: first sample at half a bit period
                    n_phase      = PH_RECV;
                    n_tick_count = reload({1'b0, i_cfg.bit_period[urxto_pkg::COUNT_W-1:1]});
                    n_bit_index  = '0;
                    n_shift_data = '0;
                end else if (i_cfg.timeout_enable) begin
                    n_wait_count = wait_inc;
                    if (wait_inc >= i_cfg.timeout_ticks) begin
                        n_phase         = PH_IDLE;
                        n_wait_count    = '0;
                        o_res_valid     = 1'b1;
                        o_res.event_res = urxto_pkg::EV_TIMEOUT;
                        o_res.data      = '0;
                    end
                end
            end else if (eff_phase == PH_RECV) begin
                if (r_tick_count > CNT_ONE) begin
                    n_tick_count = r_tick_count - CNT_ONE;
                end else begin
                    n_tick_count = reload(i_cfg.bit_period);
                    if ((r_bit_index >= BIT_FIRST_DATA) && (r_bit_index <= BIT_LAST_DATA)) begin
                        n_shift_data = {i_rx_line, r_shift_data[urxto_pkg::DATA_W-1:1]};
                    end
                    if (r_bit_index >= BIT_STOP) begin
                        // stop bit sample, level not checked
                        n_phase         = PH_IDLE;
                        n_bit_index     = '0;
                        n_tick_count    = '0;
                        o_res_valid     = 1'b1;
                        o_res.event_res = urxto_pkg::EV_BYTE;
                        o_res.data      = r_shift_data;
                    end else begin
                        n_bit_index = r_bit_index + 4'd1;
                    end
                end
            end else begin
                n_phase = PH_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_tick_count <= '0;
            r_bit_index  <= '0;
            r_shift_data <= '0;
            r_wait_count <= '0;
        end else begin
            r_phase      <= n_phase;
            r_tick_count <= n_tick_count;
            r_bit_index  <= n_bit_index;
            r_shift_data <= n_shift_data;
            r_wait_count <= n_wait_count;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/urxto_skid.sv -----
`default_nettype none
module urxto_skid (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  urxto_pkg::t_result  i_res,
    output logic                o_space,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output urxto_pkg::t_result  o_res
);

    logic               r_out_valid;
    logic               r_skid_valid;
    urxto_pkg::t_result r_out;
    urxto_pkg::t_result r_skid;
    logic               out_free;

    assign o_space     = !r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_res       = r_out;
    assign out_free    = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : i_res;
        end else if (i_push) begin
            r_skid <= i_res;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/uart_receiver_with_timeout_unit.sv -----
`default_nettype none
// 8N1 uart receiver with an optional start-bit timeout. Every input item is
// one sampling tick carrying the receive line level and a listen request; the
// block takes one item per clock cycle while input ready is high, and each
// item's effect on the receiver state is settled in the cycle that takes it.
// A listen request while idle arms the receiver, and that same tick already
// looks for a low start bit. With timeout_enable set, high-line ticks while
// waiting are counted and after timeout_ticks of them a timeout result
// (event_res 1, data 0) is given. After a start bit the line is sampled at
// half of bit_period, then once per bit_period: 8 data bits lsb first and the
// stop bit, whose level is not checked; the byte result (event_res 0) goes out
// on the stop-bit tick. Results pass through an output register backed by a
// one-entry skid stage, so input items keep flowing while a result waits;
// input ready drops only when both hold a result. Configuration writes are
// always taken and should be made only while the receiver is idle.
module uart_receiver_with_timeout_unit (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // tick items
    input  wire                                  i_in_valid,
    output logic                                 o_in_ready,
    input  wire                                  i_rx_line,
    input  wire                                  i_listen,
    // result items
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output logic                                 o_event_res,
    output logic [urxto_pkg::DATA_W-1:0]         o_data,
    // register writes
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire  [urxto_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [urxto_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    urxto_pkg::t_cfg    cfg;
    urxto_pkg::t_result core_res;
    urxto_pkg::t_result out_res;
    logic               core_res_valid;
    logic               space;
    logic               step;

    // an item is taken whenever the skid stage is empty
    assign o_in_ready = space;
    assign step       = i_in_valid && space;

    urxto_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // receiver state machine, one tick per accepted item
    urxto_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_rx_line   (i_rx_line),
        .i_listen    (i_listen),
        .i_cfg       (cfg),
        .o_res_valid (core_res_valid),
        .o_res       (core_res)
    );

    // result register with skid entry
    urxto_skid u_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (core_res_valid),
        .i_res       (core_res),
        .o_space     (space),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_res       (out_res)
    );

    assign o_event_res = out_res.event_res;
    assign o_data      = out_res.data;

endmodule
`default_nettype wire

// ----- sim/uart_receiver_with_timeout_unit_tb.sv -----
module uart_receiver_with_timeout_unit_tb;
    import urxto_pkg::*;

    localparam int unsigned CLK_HALF         = 2;
    localparam int unsigned CYCLE_LIMIT      = 200000;
    // output register plus skid stage, settle time for anything still in flight
    localparam int unsigned SETTLE_CYCLES    = 4;
    // long enough for results to fill the output register and skid entry and stall the input
    localparam int unsigned LONG_HOLD_CYCLES = 300;
    // at or below this timeout count the drain lets a waiting receiver time out
    // instead of feeding it a start bit
    localparam int unsigned SHORT_TIMEOUT    = 64;

    localparam logic [DATA_W-1:0] BYTE_PATTERNS [8] = '{
        8'h55, 8'hAA, 8'h33, 8'hCC, 8'h0F, 8'hF0, 8'h00, 8'hFF
    };

    typedef enum logic [1:0] {
        RX_IDLE = 2'd0,
        RX_WAIT = 2'd1,
        RX_RECV = 2'd2
    } rx_state_e;

    // receiver predictor plus the queue of results it still owes
    class urx_scoreboard;
        logic [COUNT_W-1:0] bit_period;
        logic               timeout_en;
        logic [COUNT_W-1:0] timeout_ticks;

        rx_state_e          state;
        logic [COUNT_W-1:0] ticks_left;
        logic [3:0]         bit_cnt;
        logic [DATA_W-1:0]  shreg;
        logic [COUNT_W-1:0] high_ticks;

        t_result            expected_events[$];
        int unsigned        mismatches;

        function new();
            bit_period    = BIT_PERIOD_RST;
            timeout_en    = TIMEOUT_ENABLE_RST;
            timeout_ticks = TIMEOUT_TICKS_RST;
            state         = RX_IDLE;
            ticks_left    = '0;
            bit_cnt       = '0;
            shreg         = '0;
            high_ticks    = '0;
            mismatches    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_BIT_PERIOD:     bit_period = value;
                CFG_TIMEOUT_ENABLE: timeout_en = value[0];
                CFG_TIMEOUT_TICKS:  timeout_ticks = value;
                default: ;
            endcase
        endfunction

        // a zero reload counts as one tick
        function logic [COUNT_W-1:0] reload(logic [COUNT_W-1:0] v);
            return (v == '0) ? COUNT_W'(1) : v;
        endfunction

        // one accepted tick item
        function void take_tick(logic rx, logic listen);
            t_result ev;
            if (state != RX_WAIT && state != RX_RECV) begin
                state = RX_IDLE;
                if (!listen)
                    return;
                // the arming tick is already a waiting tick
                state      = RX_WAIT;
                high_ticks = '0;
            end
            if (state == RX_WAIT) begin
                if (!rx) begin
                    state      = RX_RECV;
                    ticks_left = reload(bit_period >> 1);
                    bit_cnt    = '0;
                    shreg      = '0;
                    return;
                end
                if (timeout_en) begin
                    if (high_ticks != '1)
                        high_ticks++;
                    if (high_ticks >= timeout_ticks) begin
                        state         = RX_IDLE;
                        high_ticks    = '0;
                        ev.event_res  = EV_TIMEOUT;
                        ev.data       = '0;
                        expected_events.push_back(ev);
                    end
                end
                return;
            end
            // receiving: count down to the next sample point
            if (ticks_left > 1) begin
                ticks_left--;
                return;
            end
            ticks_left = reload(bit_period);
            if (bit_cnt >= 1 && bit_cnt <= 8)
                shreg = {rx, shreg[DATA_W-1:1]};
            if (bit_cnt >= 9) begin
                // stop-bit sample, level not checked
                state        = RX_IDLE;
                bit_cnt      = '0;
                ticks_left   = '0;
                ev.event_res = EV_BYTE;
                ev.data      = shreg;
                expected_events.push_back(ev);
                return;
            end
            bit_cnt++;
        endfunction

        task report(input string what, input logic [15:0] got, input logic [15:0] want);
            $display("mismatch on %s: got 0x%0h, expected 0x%0h", what, got, want);
            mismatches++;
        endtask

        task check_event(input logic ev, input logic [DATA_W-1:0] d);
            t_result want;
            if (expected_events.size() == 0) begin
                report("result with nothing pending", 16'({ev, d}), '0);
                return;
            end
            want = expected_events.pop_front();
            if (ev !== want.event_res)
                report("event_res", 16'(ev), 16'(want.event_res));
            if (d !== want.data)
                report("data", 16'(d), 16'(want.data));
        endtask

        function int unsigned outstanding();
            return expected_events.size();
        endfunction
    endclass

    // clock, reset and dut ports
    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic                  i_rx_line;
    logic                  i_listen;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic                  o_event_res;
    logic [DATA_W-1:0]     o_data;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    urx_scoreboard sb = new();

    // knobs and counters used by the sender, the sink and the watchdog
    bit          gaps_on = 1'b1;
    bit          hold_request = 1'b0;
    int unsigned items_sent = 0;
    int unsigned cycles = 0;

    uart_receiver_with_timeout_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_rx_line   (i_rx_line),
        .i_listen    (i_listen),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_event_res (o_event_res),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // result side: every accepted result is checked against the oldest one owed
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_event(o_event_res, o_data);
    end

    // sink: random stalls per result, one long hold when asked
    initial begin
        int unsigned gap;
        repeat (2) @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
            end
            gap = gaps_on ? $urandom_range(0, 9) : 0;
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
        end
    end

    // one tick item; valid stays up after acceptance so back-to-back items
    // need no second assignment in the same step
    task automatic send_tick(input logic rx, input logic listen);
        int unsigned gap;
        gap = gaps_on ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_line  <= rx;
        i_listen   <= listen;
        do @(posedge i_clk); while (!o_in_ready);
        sb.take_tick(rx, listen);
        items_sent++;
    endtask

    // line waveform of one 8n1 character at the current bit period
    task automatic send_frame(input logic [DATA_W-1:0] value, input logic arm);
        int unsigned per;
        logic        lvl;
        logic        stop_lvl;
        per      = (sb.bit_period == '0) ? 1 : sb.bit_period;
        // mostly a proper stop bit, sometimes a broken one
        stop_lvl = ($urandom_range(0, 7) != 0);
        for (int k = 0; k < 10; k++) begin
            lvl = (k == 0) ? 1'b0 : (k == 9) ? stop_lvl : value[k-1];
            for (int unsigned j = 0; j < per; j++)
                send_tick(lvl, (k == 0 && j == 0) ? arm : 1'($urandom_range(0, 3) == 0));
        end
    endtask

    // mostly well-formed characters and timeouts, the rest line noise; no_start keeps the line high
    task automatic random_traffic(input int unsigned budget, input bit no_start);
        int unsigned first;
        int unsigned pick;
        int unsigned n;
        logic [DATA_W-1:0] value;
        first = items_sent;
        while (items_sent - first < budget) begin
            pick = $urandom_range(0, 9);
            if (!no_start && pick < 6) begin
                value = $urandom_range(0, 1) ? BYTE_PATTERNS[$urandom_range(0, 7)]
                                             : 8'($urandom);
                if ($urandom_range(0, 1)) begin
                    // arm on the start-bit tick itself
                    send_frame(value, 1'b1);
                end else begin
                    send_tick(1'b1, 1'b1);
                    repeat ($urandom_range(0, 3)) send_tick(1'b1, 1'($urandom_range(0, 1)));
                    send_frame(value, 1'b0);
                end
            end else if (pick < 8) begin
                // armed with the line held high
                send_tick(1'b1, 1'b1);
                repeat ($urandom_range(0, 12)) send_tick(1'b1, 1'($urandom_range(0, 1)));
            end else begin
                n = $urandom_range(1, 20);
                repeat (n)
                    send_tick(no_start ? 1'b1 : 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
            end
        end
    endtask

    // bring the receiver back to idle, then wait for every owed result
    task automatic drain_results();
        while (sb.state != RX_IDLE) begin
            if (sb.state == RX_WAIT && !(sb.timeout_en && sb.timeout_ticks <= SHORT_TIMEOUT))
                send_tick(1'b0, 1'b0);
            else
                send_tick(1'b1, 1'b0);
        end
        i_in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, value);
    endtask

    // registers are only touched with the receiver idle and nothing in flight
    task automatic configure(input logic [COUNT_W-1:0] period, input logic ten,
                             input logic [COUNT_W-1:0] limit_ticks);
        drain_results();
        write_reg(CFG_BIT_PERIOD, period);
        write_reg(CFG_TIMEOUT_ENABLE, CFG_DATA_W'(ten));
        write_reg(CFG_TIMEOUT_TICKS, limit_ticks);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_rx_line   = 1'b1;
        i_listen    = 1'b0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_BIT_PERIOD;
        i_cfg_data  = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: idle ticks without listen do nothing
        repeat (10) send_tick(1'($urandom_range(0, 1)), 1'b0);

        // directed: arming on a start bit, listen while busy, short timeout
        configure(16'd2, 1'b1, 16'd3);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_frame(8'h55, 1'b1);
        repeat (3) send_tick(1'b1, 1'b1);

        // short period, immediate timeouts, sink stalls long enough
        // to back the block up into its input
        configure(16'd2, 1'b1, 16'd1);
        gaps_on = 1'b0;
        hold_request = 1'b1;
        random_traffic(150, 1'b0);

        // timeout off: waits forever for a start bit
        configure(16'd3, 1'b0, 16'hFFFF);
        gaps_on = 1'b1;
        random_traffic(150, 1'b0);

        // sender stops midway until everything owed has come back
        configure(16'd5, 1'b1, 16'd7);
        gaps_on = 1'b0;
        random_traffic(75, 1'b0);
        drain_results();
        random_traffic(75, 1'b0);

        // tiny period and zero timeout count
        configure(16'd1, 1'b1, 16'd0);
        gaps_on = 1'b1;
        random_traffic(100, 1'b0);

        // longest period, kept to timeouts since a character would take forever
        configure(16'hFFFF, 1'b1, 16'd2);
        gaps_on = 1'b0;
        random_traffic(60, 1'b1);

        configure(16'd8, 1'b1, 16'd40);
        gaps_on = 1'b1;
        random_traffic(200, 1'b0);

        // longest timeout count, start bits always win
        configure(16'd4, 1'b1, 16'hFFFF);
        gaps_on = 1'b0;
        random_traffic(150, 1'b0);

        configure(16'd6, 1'b0, 16'd20);
        gaps_on = 1'b1;
        random_traffic(150, 1'b0);

        drain_results();
        if (sb.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/urxto_pkg.sv
hdl/urxto_cfg.sv
hdl/urxto_core.sv
hdl/urxto_skid.sv
hdl/uart_receiver_with_timeout_unit.sv
sim/uart_receiver_with_timeout_unit_tb.sv
